@@ rtl/msb_bit_unpacker_with_peek_core_macros.svh @@
// Assertion macros for the bit reader checker.
`ifndef MSB_BIT_UNPACKER_WITH_PEEK_CORE_MACROS_SVH
`define MSB_BIT_UNPACKER_WITH_PEEK_CORE_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define MBU_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
		else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define MBU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/mbu_pkg.sv @@
`default_nettype none
package mbu_pkg;

	localparam int WORD_BITS  = 16;
	localparam int PEEK_BITS  = 13;
	localparam int STORE_BITS = 32;
	localparam int LEN_W      = 5;
	localparam int CNT_W      = 6;

	typedef enum logic {
		FUNC_PUSH    = 1'b0,
		FUNC_CONSUME = 1'b1
	} func_t;

	typedef struct packed {
		func_t                func;
		logic [WORD_BITS-1:0] word;
		logic [LEN_W-1:0]     bit_len;
	} item_t;

	typedef struct packed {
		logic [STORE_BITS-1:0] store;
		logic [CNT_W-1:0]      count;
	} rdr_state_t;

	typedef struct packed {
		logic [WORD_BITS-1:0] bits;
		logic [PEEK_BITS-1:0] peek;
		logic [CNT_W-1:0]     held;
		logic                 underflow;
		logic                 overflow;
	} result_t;

endpackage
`default_nettype wire

@@ rtl/msb_bit_unpacker_with_peek_core.sv @@
`default_nettype none
// MSB-first bit reader for a Huffman decoder front end. Each slave-side
// transaction either pushes a 16-bit stream word (tuser = 0) into a 32-bit bit
// store or consumes 0..16 bits from it (tuser = 1); a consume of 0 bits only
// peeks. Every transaction yields exactly one master-side transaction that
// carries the consumed bits right-aligned, the next 13 stream bits (zero-padded
// on the right when fewer are held) and the count of held bits. A consume that
// asks for more bits than are held, or for more than 16, is refused with the
// underflow flag and changes nothing; a push while more than 16 bits are held
// is dropped with the overflow flag. One transaction per cycle is sustained
// while the master side accepts: an input register feeds a single
// shift-and-count step that updates the store and writes the output register
// in the same cycle, where the result waits until the master side takes it;
// a stalled master side holds the input back.
module msb_bit_unpacker_with_peek_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,  // [15:0] word, [20:16] bit_len, [23:21] zero
	input  wire logic        s_axis_tuser,  // [0] func
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,  // [15:0] bits, [28:16] peek, [34:29] held,
	                                        // [39:35] zero
	output logic [1:0]       m_axis_tuser   // [0] underflow, [1] overflow
);
	import mbu_pkg::*;

	item_t      in_item;
	item_t      item_s1;
	logic       valid_s1;
	logic       advance;
	rdr_state_t state_q;
	rdr_state_t state_nxt;
	result_t    res;
	result_t    res_q;

	// Unpack the slave-side payload.
	assign in_item.func    = func_t'(s_axis_tuser);
	assign in_item.word    = s_axis_tdata[WORD_BITS-1:0];
	assign in_item.bit_len = s_axis_tdata[WORD_BITS+LEN_W-1:WORD_BITS];

	// The item in stage 1 executes when the output register is free or drains.
	assign advance = valid_s1 && (!m_axis_tvalid || m_axis_tready);

	mbu_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	mbu_step u_step (
		.item (item_s1),
		.cur  (state_q),
		.nxt  (state_nxt),
		.res  (res)
	);

	// Bit store and count: commit only when the item executes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (advance) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_axis_tdata = {5'b0, res_q.held, res_q.peek, res_q.bits};
	assign m_axis_tuser = {res_q.overflow, res_q.underflow};

endmodule
`default_nettype wire

@@ rtl/mbu_in_stage.sv @@
`default_nettype none
module mbu_in_stage (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire mbu_pkg::item_t in_item,
	input  wire logic          advance,
	output logic               valid_s1,
	output mbu_pkg::item_t     item_s1
);
	import mbu_pkg::*;

	// Stage can load whenever it is empty or its item moves on this cycle.
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule
`default_nettype wire

@@ rtl/mbu_step.sv @@
`default_nettype none
module mbu_step (
	input  wire mbu_pkg::item_t     item,
	input  wire mbu_pkg::rdr_state_t cur,
	output mbu_pkg::rdr_state_t     nxt,
	output mbu_pkg::result_t        res
);
	import mbu_pkg::*;

	logic                  over;
	logic                  under;
	logic [CNT_W-1:0]      rest;
	logic [STORE_BITS-1:0] shifted;
	logic [WORD_BITS-1:0]  taken;
	logic [CNT_W-1:0]      peek_sh;

	assign over  = cur.count > CNT_W'(STORE_BITS - WORD_BITS);
	assign under = (item.bit_len > LEN_W'(WORD_BITS)) ||
		(CNT_W'(item.bit_len) > cur.count);
	assign rest    = cur.count - CNT_W'(item.bit_len);
	assign shifted = cur.store >> rest;
	assign taken   = shifted[WORD_BITS-1:0] & ~({WORD_BITS{1'b1}} << item.bit_len);

	always_comb begin
		nxt           = cur;
		res.bits      = '0;
		res.underflow = 1'b0;
		res.overflow  = 1'b0;
		case (item.func)
			FUNC_PUSH: begin
				if (over) begin
					res.overflow = 1'b1;
				end else begin
					nxt.store = {cur.store[STORE_BITS-WORD_BITS-1:0], item.word};
					nxt.count = cur.count + CNT_W'(WORD_BITS);
				end
			end
			FUNC_CONSUME: begin
				if (under) begin
					res.underflow = 1'b1;
				end else begin
					res.bits  = taken;
					nxt.store = cur.store & ~({STORE_BITS{1'b1}} << rest);
					nxt.count = rest;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase

		// Peek window on the updated store; zero-pad on the right when short.
		if (nxt.count >= CNT_W'(PEEK_BITS)) begin
			peek_sh  = nxt.count - CNT_W'(PEEK_BITS);
			res.peek = PEEK_BITS'(nxt.store >> peek_sh);
		end else begin
			peek_sh  = CNT_W'(PEEK_BITS) - nxt.count;
			res.peek = PEEK_BITS'(nxt.store << peek_sh);
		end

		res.held = nxt.count;
	end

endmodule
`default_nettype wire

@@ rtl/mbu_checker.sv @@
`default_nettype none
`include "msb_bit_unpacker_with_peek_core_macros.svh"
module mbu_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [39:0] m_axis_tdata,
	input wire logic [1:0]  m_axis_tuser
);

	// Held count never exceeds the store size.
	`MBU_ASSERT_ALWAYS(a_held_range, clk, arst_n,
		!m_axis_tvalid || (m_axis_tdata[34:29] <= 6'd32), "held above 32")

	// A step cannot be refused as both a push and a consume.
	`MBU_ASSERT_ALWAYS(a_flags_excl, clk, arst_n,
		!m_axis_tvalid || (m_axis_tuser != 2'b11), "underflow and overflow together")

	// Refused results carry no consumed bits.
	`MBU_ASSERT_ALWAYS(a_refused_bits, clk, arst_n,
		!m_axis_tvalid || (m_axis_tuser == 2'b00) || (m_axis_tdata[15:0] == 16'd0),
		"bits nonzero on refused step")

	// A stalled result holds.
	`MBU_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
		"result changed while stalled")

	// With an empty store (held equal to zero), the peek is zero.
	`MBU_ASSERT_ALWAYS(a_empty_peek, clk, arst_n,
		!m_axis_tvalid || (m_axis_tdata[34:29] != 6'd0) || (m_axis_tdata[28:16] == 13'd0),
		"peek nonzero with nothing held")

endmodule

bind msb_bit_unpacker_with_peek_core mbu_checker u_mbu_checker (.*);
`default_nettype wire
